@@ design/fat12_cluster_chain_walker_defines.svh @@
// Assertion macros for the cluster chain walker RTL.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define FCCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fccw assertion failed");

// Next-cycle implication, checked outside reset.
`define FCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fccw assertion failed");

`else

`define FCCW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/fccw_pkg.sv @@
// Types and constants of the FAT12 cluster chain walker.
package fccw_pkg;

    localparam int TBL_ADDR_W = 13;
    localparam int CLUSTER_W  = 12;
    localparam int SECTOR_W   = 20;
    localparam int LBA_W      = 16;
    localparam int SPC_W      = 8;
    localparam int CNT_W      = $clog2(SPC_W);

    localparam logic [CLUSTER_W-1:0] END_MARK      = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] FIRST_DATA_CL = 12'd2;
    localparam logic [SECTOR_W-1:0]  MINUS_FIRST   = 20'hFFFFE;  // -2 mod 2^20
    localparam int                   ODD_SHIFT     = 4;

    localparam logic [LBA_W-1:0] DSL_RESET = 16'd33;
    localparam logic [SPC_W-1:0] SPC_RESET = 8'd1;

    // commands
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    // result status
    localparam logic [1:0] ST_WRITTEN = 2'd0;
    localparam logic [1:0] ST_GIVEN   = 2'd1;
    localparam logic [1:0] ST_ENDED   = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    // register indexes
    localparam logic REG_DSL = 1'b0;
    localparam logic REG_SPC = 1'b1;

    typedef struct packed {
        logic [1:0]            command;
        logic [TBL_ADDR_W-1:0] table_address;
        logic [7:0]            table_byte;
        logic [CLUSTER_W-1:0]  start_cluster;
    } t_in_word;

    typedef struct packed {
        logic [1:0]           status;
        logic [CLUSTER_W-1:0] cluster;
        logic [SECTOR_W-1:0]  sector_address;
        logic [CLUSTER_W-1:0] next_cluster;
        logic                 last_in_chain;
    } t_out_word;

    typedef struct packed {
        logic                  wr;
        logic                  rd;
        logic [TBL_ADDR_W-1:0] addr;
        logic [7:0]            wdata;
    } t_tbl_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OFF,
        S_SUB,
        S_RD0,
        S_RD1,
        S_MUL,
        S_DONE
    } t_state;

endpackage

@@ design/fccw_table.sv @@
// Single-port allocation table byte store with registered read.
module fccw_table
    import fccw_pkg::*;
#(
    parameter int TABLE_BYTES = 8192
) (
    input  logic       i_clk,
    input  t_tbl_req   i_req,
    output logic [7:0] o_rdata
);

    localparam int AW = $clog2(TABLE_BYTES);
    localparam logic [TBL_ADDR_W:0] LIMIT = (TBL_ADDR_W + 1)'(TABLE_BYTES);

    logic [7:0] r_mem [TABLE_BYTES];
    logic [7:0] r_rdata;
    logic       r_ok;
    logic       in_range;

    assign in_range = {1'b0, i_req.addr} < LIMIT;

    always_ff @(posedge i_clk) begin
        if (i_req.wr && in_range) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr[AW-1:0]];
            r_ok    <= in_range;
        end
    end

    // bytes beyond the table read as zero
    assign o_rdata = r_ok ? r_rdata : 8'd0;

endmodule

@@ design/fat12_cluster_chain_walker.sv @@
// Top level of the FAT12 cluster chain walker: sequencer, shared adder, APB registers.
//
// Walks a FAT12 cluster chain held in an internal byte table. Load the table
// with write words (command 0), one byte each; every entry must be written
// before a chain step reads it. A start word (command 1) names the first
// cluster and returns it; each advance word (command 2) returns the next one.
// A returned word carries the cluster, its first sector
// (data_start_lba + (cluster - 2) * sectors_per_cluster, modulo 2^20), the
// next cluster from the table and a last-in-chain flag (next >= 0xFF8).
// Ended chains, command 3 and clusters below 2 are answered at once with
// status 2 or 3. A write word, or any word answered at once, leaves the
// sequencer idle. A chain step that reads the table keeps the block busy
// from acceptance to the next ready: one adder is shared by the offset sum
// cluster*3/2, the cluster - 2 subtract, the second byte address and an
// eight-step shift-add multiply by sectors_per_cluster, and the two table
// bytes come one after another from a single-port memory. The result sits in
// an output register. A new word is taken only while that register is empty
// or being read, and a finished chain step waits in its last state until it
// is, so a stalled receiver holds off every word for as long as it stalls.
// data_start_lba is at byte address 0, sectors_per_cluster at 4; write them
// only while the block is idle.

`include "fat12_cluster_chain_walker_defines.svh"

module fat12_cluster_chain_walker
    import fccw_pkg::*;
#(
    parameter int TABLE_BYTES = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    t_state               r_state, n_state;
    logic [CLUSTER_W-1:0] r_cl;        // cluster being given
    logic [TBL_ADDR_W-1:0] r_off;      // table byte address
    logic [SECTOR_W-1:0]  r_mcand;     // (cluster - 2), shifted left per step
    logic [SPC_W-1:0]     r_mult;      // sectors per cluster, shifted right
    logic [SECTOR_W-1:0]  r_acc;       // sector address accumulator
    logic [CNT_W-1:0]     r_cnt;
    logic [15:0]          r_pair;      // little-endian entry pair
    logic [CLUSTER_W-1:0] r_cur;       // cluster the next advance gives
    logic [LBA_W-1:0]     r_dsl;
    logic [SPC_W-1:0]     r_spc;
    logic                 r_out_valid;
    t_out_word            r_out;

    // shared adder
    logic [SECTOR_W-1:0]  add_a, add_b, add_sum;
    assign add_sum = add_a + add_b;

    // table
    t_tbl_req             tbl_req;
    logic [7:0]           tbl_rdata;

    fccw_table #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_table (
        .i_clk   (i_clk),
        .i_req   (tbl_req),
        .o_rdata (tbl_rdata)
    );

    // ---------------------------------------------------------------
    // handshake and immediate decode
    // ---------------------------------------------------------------
    logic                 out_free;
    logic                 accept;
    logic [CLUSTER_W-1:0] sel_cl;
    logic                 go_seq;
    logic                 imm_load;
    t_out_word            imm_out;
    logic [CLUSTER_W-1:0] imm_cur;
    logic                 done_load;
    logic [CLUSTER_W-1:0] entry;
    t_out_word            done_out;
    logic                 mul_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = i_in_valid && o_in_ready;
    assign sel_cl   = (i_in_word.command == CMD_START) ? i_in_word.start_cluster : r_cur;

    // Words answered without a table walk; a start always loads the chain.
    always_comb begin
        imm_out = '0;
        imm_cur = r_cur;
        go_seq  = 1'b0;
        unique case (i_in_word.command)
            CMD_WRITE: begin
                imm_out.status = ST_WRITTEN;
            end
            CMD_START, CMD_ADVANCE: begin
                imm_cur = sel_cl;
                if (sel_cl >= END_MARK) begin
                    imm_out.status = ST_ENDED;
                end else if (sel_cl < FIRST_DATA_CL) begin
                    imm_out.status  = ST_BAD;
                    imm_out.cluster = sel_cl;
                    imm_cur         = END_MARK;
                end else begin
                    go_seq = 1'b1;
                end
            end
            default: begin
                imm_out.status = ST_ENDED;
            end
        endcase
    end

    assign imm_load = accept && !go_seq;

    // even clusters take the low 12 bits, odd ones the high 12
    assign entry = r_cl[0] ? r_pair[ODD_SHIFT +: CLUSTER_W] : r_pair[CLUSTER_W-1:0];

    always_comb begin
        done_out                = '0;
        done_out.status         = ST_GIVEN;
        done_out.cluster        = r_cl;
        done_out.sector_address = r_acc;
        done_out.next_cluster   = entry;
        done_out.last_in_chain  = entry >= END_MARK;
    end

    assign done_load = (r_state == S_DONE) && out_free;

    // last of the eight multiply steps
    assign mul_last = (r_state == S_MUL) && (r_cnt == CNT_W'(SPC_W - 1));

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && go_seq) n_state = S_OFF;
            S_OFF:  n_state = S_SUB;
            S_SUB:  n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_MUL;
            S_MUL:  if (mul_last) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: outputs (adder operands, table port, ready)
    // ---------------------------------------------------------------
    always_comb begin
        add_a      = r_acc;
        add_b      = '0;
        tbl_req    = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = out_free;
                tbl_req.wr    = accept && (i_in_word.command == CMD_WRITE);
                tbl_req.addr  = i_in_word.table_address;
                tbl_req.wdata = i_in_word.table_byte;
            end
            S_OFF: begin
                // cluster * 3 / 2 = cluster + cluster / 2
                add_a = SECTOR_W'(r_cl);
                add_b = SECTOR_W'(r_cl[CLUSTER_W-1:1]);
            end
            S_SUB: begin
                add_a = SECTOR_W'(r_cl);
                add_b = MINUS_FIRST;
            end
            S_RD0: begin
                tbl_req.rd   = 1'b1;
                tbl_req.addr = r_off;
                add_a        = SECTOR_W'(r_off);
                add_b        = SECTOR_W'(1);
            end
            S_RD1: begin
                tbl_req.rd   = 1'b1;
                tbl_req.addr = r_off;
            end
            S_MUL: begin
                add_a = r_acc;
                add_b = r_mult[0] ? r_mcand : '0;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cl   <= sel_cl;
                    r_acc  <= SECTOR_W'(r_dsl);
                    r_mult <= r_spc;
                    r_cnt  <= '0;
                end
            end
            S_OFF: r_off   <= add_sum[TBL_ADDR_W-1:0];
            S_SUB: r_mcand <= SECTOR_W'(add_sum[CLUSTER_W-1:0]);
            S_RD0: r_off   <= add_sum[TBL_ADDR_W-1:0];
            S_RD1: r_pair[7:0] <= tbl_rdata;
            S_MUL: begin
                if (r_cnt == '0) begin
                    r_pair[15:8] <= tbl_rdata;
                end
                r_acc   <= add_sum;
                r_mcand <= r_mcand << 1;
                r_mult  <= r_mult >> 1;
                r_cnt   <= r_cnt + CNT_W'(1);
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase

        if (imm_load) begin
            r_out <= imm_out;
        end else if (done_load) begin
            r_out <= done_out;
        end
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cur       <= END_MARK;
            r_dsl       <= DSL_RESET;
            r_spc       <= SPC_RESET;
        end else begin
            r_state <= n_state;

            if (imm_load || done_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (accept) begin
                r_cur <= imm_cur;
            end else if (done_load) begin
                r_cur <= entry;
            end

            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_DSL: r_dsl <= pwdata[LBA_W-1:0];
                    REG_SPC: r_spc <= pwdata[SPC_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DSL: prdata = 32'(r_dsl);
            REG_SPC: prdata = 32'(r_spc);
            default: prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    logic given_out;
    logic last_ok;
    assign given_out = o_out_valid && (o_out_word.status == ST_GIVEN);
    assign last_ok   = o_out_word.last_in_chain == (o_out_word.next_cluster >= END_MARK);

    `FCCW_ASSERT_NOW(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !o_in_ready)
    `FCCW_ASSERT_NEXT(a_walk_starts, i_clk, i_rst_n, accept && go_seq, r_state == S_OFF)
    `FCCW_ASSERT_NEXT(a_mul_ends, i_clk, i_rst_n, mul_last, r_state == S_DONE)
    `FCCW_ASSERT_NOW(a_last_flag, i_clk, i_rst_n, given_out, last_ok)

endmodule
